[rtl/mse_pkg.sv]
`timescale 1ns / 1ps

package mse_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // One entry of the sorting chain.
  typedef struct packed {
    logic  valid;
    data_t value;
  } slot_t;

  // Commands from the controller to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

  // Result-side status from the controller.
  typedef struct packed {
    logic strobe;
    logic end_of_set;
    logic overflow;
  } out_stat_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

[rtl/merge_sort_engine.sv]
`timescale 1ns / 1ps

// Channel   Ports                                           Handshake
// input     in_value[31:0] signed, in_last                  start && !busy
// result    out_sorted_value[31:0] signed, out_end_of_set,  out_valid, one cycle,
//           out_overflow                                    no back-pressure
//
// Each accepted item is inserted into a sorted chain of MAX_ITEMS cells in the
// same cycle. The item with in_last set closes the set; starting on the next
// cycle the chain shifts toward cell 0 and one result leaves per cycle until
// all N stored items of the set are out; busy is high throughout the drain.
// Reset is synchronous and active low; it empties the chain and the counters.
// Results cannot be stalled: each is shown for exactly one cycle.
//
// Sorting is a systolic insertion: every cell compares its entry with the
// arriving item and, together with its left neighbor's decision, keeps its
// entry, takes the item, or takes the neighbor's entry. Equal values are
// identical words, so the order among ties is invisible at the outputs and
// matches a stable sort. Items that arrive while the chain is full are
// dropped, and every result of that set carries out_overflow.
module merge_sort_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    in_value,
  input  logic                  in_last,
  output logic                  out_valid,
  output logic signed [31:0]    out_sorted_value,
  output logic                  out_end_of_set,
  output logic                  out_overflow
);

  mse_pkg::cell_ctl_t ctl;
  mse_pkg::out_stat_t stat;
  mse_pkg::slot_t     slots [mse_pkg::MAX_ITEMS];
  logic               keeps [mse_pkg::MAX_ITEMS];

  mse_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_last),
    .busy    (busy),
    .ctl     (ctl),
    .stat    (stat)
  );

  // The chain. Cell 0 sees a left neighbor that always keeps, so an item that
  // is smaller than every entry lands there; the last cell sees an empty
  // right neighbor, which drains in as the chain empties.
  for (genvar i = 0; i < mse_pkg::MAX_ITEMS; i++) begin : g_cell
    mse_pkg::slot_t prev_slot;
    mse_pkg::slot_t next_slot;
    logic           prev_keep;

    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
      assign prev_slot = '{valid: 1'b1, value: in_value};
    end else begin : g_body
      assign prev_keep = keeps[i-1];
      assign prev_slot = slots[i-1];
    end

    if (i == mse_pkg::MAX_ITEMS - 1) begin : g_tail
      assign next_slot = '{valid: 1'b0, value: '0};
    end else begin : g_link
      assign next_slot = slots[i+1];
    end

    mse_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_value (in_value),
      .prev_keep (prev_keep),
      .prev_slot (prev_slot),
      .next_slot (next_slot),
      .slot      (slots[i]),
      .keep      (keeps[i])
    );
  end

  // Results come straight from cell 0 and the controller's registers.
  assign out_valid        = stat.strobe;
  assign out_sorted_value = slots[0].value;
  assign out_end_of_set   = stat.end_of_set;
  assign out_overflow     = stat.overflow;

endmodule

[rtl/mse_cell.sv]
`timescale 1ns / 1ps

// One cell of the insertion chain. The chain stays sorted ascending, with
// empty cells at the tail. On insert a cell keeps its entry if it is not
// greater than the new value, takes the new value if its left neighbor kept,
// and otherwise takes its left neighbor's entry. On shift it takes the entry
// of its right neighbor.
module mse_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  mse_pkg::cell_ctl_t ctl,
  input  mse_pkg::data_t    new_value,
  input  logic              prev_keep,
  input  mse_pkg::slot_t    prev_slot,
  input  mse_pkg::slot_t    next_slot,
  output mse_pkg::slot_t    slot,
  output logic              keep
);

  logic           valid_r;
  logic           valid_nxt;
  mse_pkg::data_t value_r;
  mse_pkg::data_t value_nxt;

  assign keep = valid_r && (value_r <= new_value);
  assign slot = '{valid: valid_r, value: value_r};

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctl.insert) begin
      if (!keep) begin
        if (prev_keep) begin
          valid_nxt = 1'b1;
          value_nxt = new_value;
        end else begin
          valid_nxt = prev_slot.valid;
          value_nxt = prev_slot.value;
        end
      end
    end else if (ctl.shift) begin
      valid_nxt = next_slot.valid;
      value_nxt = next_slot.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

[rtl/mse_ctrl.sv]
`timescale 1ns / 1ps

// Load/drain controller: counts stored items, notes dropped ones and paces
// the drain of the chain.
module mse_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 in_last,
  output logic                 busy,
  output mse_pkg::cell_ctl_t   ctl,
  output mse_pkg::out_stat_t   stat
);

  mse_pkg::state_t state_r;
  mse_pkg::state_t state_nxt;
  mse_pkg::cnt_t   count_r;
  mse_pkg::cnt_t   count_nxt;
  mse_pkg::cnt_t   remain_r;
  mse_pkg::cnt_t   remain_nxt;
  logic            dropped_r;
  logic            dropped_nxt;
  logic            accept;
  logic            room;

  assign room   = count_r < mse_pkg::CNT_W'(mse_pkg::MAX_ITEMS);
  assign accept = start && (state_r == mse_pkg::ST_LOAD);

  // Next state and counters.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    remain_nxt  = remain_r;
    dropped_nxt = dropped_r;
    unique case (state_r)
      mse_pkg::ST_LOAD: begin
        if (accept) begin
          if (room) begin
            count_nxt = count_r + 1'b1;
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt  = mse_pkg::ST_DRAIN;
            remain_nxt = count_r + mse_pkg::cnt_t'(room);
            count_nxt  = '0;
          end
        end
      end
      mse_pkg::ST_DRAIN: begin
        remain_nxt = remain_r - 1'b1;
        if (remain_r == mse_pkg::cnt_t'(1)) begin
          state_nxt   = mse_pkg::ST_LOAD;
          dropped_nxt = 1'b0;
        end
      end
      default: state_nxt = mse_pkg::ST_LOAD;
    endcase
  end

  // Outputs.
  always_comb begin
    busy            = 1'b0;
    ctl.insert      = 1'b0;
    ctl.shift       = 1'b0;
    stat.strobe     = 1'b0;
    stat.end_of_set = 1'b0;
    stat.overflow   = dropped_r;
    unique case (state_r)
      mse_pkg::ST_LOAD: begin
        ctl.insert = accept && room;
      end
      mse_pkg::ST_DRAIN: begin
        busy            = 1'b1;
        ctl.shift       = 1'b1;
        stat.strobe     = 1'b1;
        stat.end_of_set = (remain_r == mse_pkg::cnt_t'(1));
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mse_pkg::ST_LOAD;
      count_r   <= '0;
      remain_r  <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      remain_r  <= remain_nxt;
      dropped_r <= dropped_nxt;
    end
  end

endmodule

[rtl/mse_checker.sv]
`timescale 1ns / 1ps

module mse_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               in_last,
  input logic               out_valid,
  input logic signed [31:0] out_sorted_value,
  input logic               out_end_of_set,
  input logic               out_overflow
);

  // A drain begins only after a closing item was accepted.
  a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_last))
    else $error("drain started without a closing item");

  // The final result of a set frees the input side.
  a_end_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_set) |=> !busy)
    else $error("still busy after the final result");

  // Results of one set come in consecutive cycles.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_end_of_set) |=> out_valid)
    else $error("gap inside a set");

  // Results of one set come in ascending order.
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_end_of_set) |=> out_sorted_value >= $past(out_sorted_value))
    else $error("results out of order");

  // The overflow mark is the same on every result of a set.
  a_overflow_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_end_of_set) |=> out_overflow == $past(out_overflow))
    else $error("overflow mark changed within a set");

endmodule

bind merge_sort_engine mse_checker u_mse_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_last          (in_last),
  .out_valid        (out_valid),
  .out_sorted_value (out_sorted_value),
  .out_end_of_set   (out_end_of_set),
  .out_overflow     (out_overflow)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  // Clock period in ns, and the number of random input items to send.
  localparam int CLK_PERIOD   = 12;
  localparam int RANDOM_ITEMS = 370;

  // One sorted element as it should leave the block.
  typedef struct packed {
    mse_pkg::data_t value;
    logic           end_of_set;
    logic           overflow;
  } sorted_elem_t;

  // The class keeps its own copy of the set being loaded, always in
  // ascending order. An element is added behind every element that is less
  // than or equal to it, so ties keep their arrival order. When the closing
  // item arrives, the whole set becomes the queue of expected results.
  class sort_checker;
    mse_pkg::data_t loaded_set[$];
    bit             set_dropped;
    sorted_elem_t   expected_sorted[$];
    int             errors;

    function new();
      set_dropped = 1'b0;
      errors      = 0;
    endfunction

    task report(input string msg);
      $display("MISMATCH at %0t ns: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return expected_sorted.size();
    endfunction

    // Called for every item that the block accepts.
    function void take_value(input mse_pkg::data_t v, input logic last);
      int             i;
      mse_pkg::data_t tmp;
      sorted_elem_t   elem;
      if (loaded_set.size() < mse_pkg::MAX_ITEMS) begin
        loaded_set.push_back(v);
        // Walk the new element down past every strictly greater one.
        for (i = loaded_set.size() - 1; i > 0; i--) begin
          if (loaded_set[i-1] <= loaded_set[i]) break;
          tmp             = loaded_set[i-1];
          loaded_set[i-1] = loaded_set[i];
          loaded_set[i]   = tmp;
        end
      end else begin
        set_dropped = 1'b1;
      end
      if (last) begin
        for (i = 0; i < loaded_set.size(); i++) begin
          elem.value      = loaded_set[i];
          elem.end_of_set = (i == loaded_set.size() - 1);
          elem.overflow   = set_dropped;
          expected_sorted.push_back(elem);
        end
        loaded_set.delete();
        set_dropped = 1'b0;
      end
    endfunction

    // Called for every result the block presents.
    task check_result(input mse_pkg::data_t v, input logic eos, input logic ovf);
      sorted_elem_t exp_elem;
      if (expected_sorted.size() == 0) begin
        report($sformatf("result %0d with nothing pending", v));
      end else begin
        exp_elem = expected_sorted.pop_front();
        if (v !== exp_elem.value)
          report($sformatf("sorted_value %0d, expected %0d", v, exp_elem.value));
        if (eos !== exp_elem.end_of_set)
          report($sformatf("end_of_set %b, expected %b on value %0d", eos,
                           exp_elem.end_of_set, exp_elem.value));
        if (ovf !== exp_elem.overflow)
          report($sformatf("overflow %b, expected %b on value %0d", ovf,
                           exp_elem.overflow, exp_elem.value));
      end
    endtask
  endclass

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  mse_pkg::data_t in_value;
  logic           in_last;
  logic           out_valid;
  mse_pkg::data_t out_sorted_value;
  logic           out_end_of_set;
  logic           out_overflow;

  sort_checker    tracker;

  merge_sort_engine dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_end_of_set   (out_end_of_set),
    .out_overflow     (out_overflow)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // Results cannot be held off, so every cycle with out_valid high is one
  // result, taken at the rising edge that closes the cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      tracker.check_result(out_sorted_value, out_end_of_set, out_overflow);
  end

  // Present one item from the falling edge on and keep it until a rising
  // edge sees busy low, which is the edge that takes the item.
  task automatic push_value(input mse_pkg::data_t v, input logic last);
    @(negedge clk);
    start    <= 1'b1;
    in_value <= v;
    in_last  <= last;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.take_value(v, last);
  endtask

  // Leave the input idle for the given number of cycles. The data lines carry junk during
  // the gap, which the block has to ignore while start is low.
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start    <= 1'b0;
      in_value <= $urandom;
      in_last  <= 1'($urandom_range(0, 1));
    end
  endtask

  // Wait until every result that has been predicted has come out.
  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Mix of fully random words, extremes, and a narrow band around zero so
  // that sets often contain equal values.
  function automatic mse_pkg::data_t pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return mse_pkg::data_t'($urandom);
    if (sel < 80) return mse_pkg::data_t'($signed($urandom_range(0, 8)) - 4);
    if (sel < 87) return {1'b1, {(mse_pkg::DATA_W-1){1'b0}}};
    if (sel < 94) return {1'b0, {(mse_pkg::DATA_W-1){1'b1}}};
    return mse_pkg::data_t'($urandom_range(0, 1) ? 0 : -1);
  endfunction

  // Mostly short sets; the large ones are forced in the main loop.
  function automatic int pick_size();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(1, 8);
    if (sel < 90) return $urandom_range(9, 20);
    return $urandom_range(21, 40);
  endfunction

  task automatic send_random_set(input int size, input int idle_pct);
    int i;
    for (i = 0; i < size; i++) begin
      if ($urandom_range(0, 99) < idle_pct)
        hold_off($urandom_range(1, 6));
      push_value(pick_value(), i == size - 1);
    end
  endtask

  initial begin
    int             random_sent;
    int             set_no;
    int             size;
    int             phase;
    int             idle_pct;
    bit             paused;
    mse_pkg::data_t min_val;
    mse_pkg::data_t max_val;

    tracker  = new();
    min_val  = {1'b1, {(mse_pkg::DATA_W-1){1'b0}}};
    max_val  = {1'b0, {(mse_pkg::DATA_W-1){1'b1}}};
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;
    in_last  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed sets. Single-element sets at the extremes of the range, at zero and at minus one.
    push_value(min_val, 1'b1);
    push_value(max_val, 1'b1);
    push_value(0, 1'b1);
    push_value(-1, 1'b1);
    // Two elements in reverse order, spanning the whole range.
    push_value(max_val, 1'b0);
    push_value(min_val, 1'b1);
    // All elements equal.
    push_value(5, 1'b0);
    push_value(5, 1'b0);
    push_value(5, 1'b1);
    // Ties mixed with signs, so the comparison must be signed.
    push_value(3, 1'b0);
    push_value(-3, 1'b0);
    push_value(0, 1'b0);
    push_value(3, 1'b0);
    push_value(-3, 1'b0);
    push_value(min_val, 1'b1);
    // Already ascending, then strictly descending.
    push_value(1, 1'b0);
    push_value(2, 1'b0);
    push_value(3, 1'b0);
    push_value(max_val, 1'b1);
    push_value(max_val, 1'b0);
    push_value(2, 1'b0);
    push_value(-2, 1'b0);
    push_value(min_val, 1'b1);

    // Random sets in four stretches: no gaps, frequent gaps, occasional gaps,
    // and no gaps again. A few sets are forced to the interesting sizes: a
    // set that exactly fills the store, one whose closing item is the first
    // to be dropped, and one that drops several items.
    random_sent = 0;
    set_no      = 0;
    paused      = 1'b0;
    while (random_sent < RANDOM_ITEMS) begin
      phase = (random_sent * 4) / RANDOM_ITEMS;
      case (phase)
        0:       idle_pct = 0;
        1:       idle_pct = 64;
        2:       idle_pct = 26;
        default: idle_pct = 0;
      endcase
      // Once, let the block go completely quiet before the next set.
      if (phase == 2 && !paused) begin
        hold_off(1);
        wait_drained();
        paused = 1'b1;
      end
      case (set_no)
        4:       size = mse_pkg::MAX_ITEMS;
        9:       size = mse_pkg::MAX_ITEMS + 1;
        14:      size = $urandom_range(mse_pkg::MAX_ITEMS + 2, mse_pkg::MAX_ITEMS + 6);
        default: size = pick_size();
      endcase
      send_random_set(size, idle_pct);
      random_sent += size;
      set_no++;
    end
    hold_off(1);

    // Let the last set drain, then give the block time to show anything
    // unexpected before deciding.
    wait_drained();
    repeat (mse_pkg::MAX_ITEMS + 8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung run; it leaves a wide margin over a correct run
  // for gaps and drains.
  initial begin
    #(400000 * CLK_PERIOD);
    $display("Timeout waiting for the block");
    $display("Some tests failed");
    $finish;
  end

endmodule
